### design/atsu_pkg.sv
// ----------------------------------------------------------------------------
// atsu_pkg: shared types and constants of the authority time sync unit
// Mode codes, register indexes, reset values and controller/datapath links.
// ----------------------------------------------------------------------------
package atsu_pkg;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_DELAY = 2'd1,
    MODE_SYNC  = 2'd2,
    MODE_TICK  = 2'd3
  } mode_e;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL = 2'd1;

  localparam logic [15:0] TIMEOUT_RESET     = 16'd3840;
  localparam logic [15:0] LEVEL_RESET       = 16'd2555;
  localparam logic [31:0] DELAY_SUM_RESET   = 32'd40;
  localparam logic [15:0] DELAY_COUNT_RESET = 16'd1;
  localparam logic [15:0] DELAY_COUNT_LIMIT = 16'd1000;
  localparam logic [15:0] DELAY_COUNT_MAX   = 16'd1001;
  localparam logic [15:0] SENDER_LEVEL_LIM  = 16'd2000;
  localparam logic [15:0] LEVEL_MAX         = 16'hFFFF;
  localparam logic [15:0] DRIFT_DIVISOR     = 16'd3;
  // floor(x / 3) == (x * DRIFT_RECIP) >> 33 for every 32-bit x
  localparam logic [31:0] DRIFT_RECIP       = 32'hAAAA_AAAB;

  typedef enum logic {
    DIV_SEL_LOCAL = 1'b0,
    DIV_SEL_DRIFT = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_step;
    logic     drift_mul;
    logic     apply;
    logic     out_load;
  } atsu_cmd_t;

  typedef struct packed {
    logic is_sync;
    logic div_last;
  } atsu_status_t;

endpackage

### design/atsu_ctrl.sv
// ----------------------------------------------------------------------------
// atsu_ctrl: sequencer of the authority time sync unit
// Walks one request through capture, division, state update and result.
// ----------------------------------------------------------------------------
module atsu_ctrl import atsu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  atsu_status_t status_i,
  output atsu_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV_LOCAL,
    ST_APPLY,
    ST_DRIFT_LOAD,
    ST_DRIFT_MUL,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DIV_SEL_LOCAL;
    case (state_q)
      ST_IDLE:       cmd_o.load_in = in_valid_i;
      ST_DISPATCH:   cmd_o.div_start = status_i.is_sync;
      ST_DIV_LOCAL:  cmd_o.div_step = 1'b1;
      ST_APPLY:      cmd_o.apply = 1'b1;
      ST_DRIFT_LOAD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SEL_DRIFT;
      end
      ST_DRIFT_MUL:  cmd_o.drift_mul = 1'b1;
      ST_DONE:       cmd_o.out_load = out_free;
      default:       cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE:       if (in_valid_i) state_q <= ST_DISPATCH;
        ST_DISPATCH:   state_q <= status_i.is_sync ? ST_DIV_LOCAL : ST_APPLY;
        ST_DIV_LOCAL:  if (status_i.div_last) state_q <= ST_APPLY;
        ST_APPLY:      state_q <= ST_DRIFT_LOAD;
        ST_DRIFT_LOAD: state_q <= ST_DRIFT_MUL;
        ST_DRIFT_MUL:  state_q <= ST_DONE;
        ST_DONE:       if (out_free) state_q <= ST_IDLE;
        default:       state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/atsu_dp.sv
// ----------------------------------------------------------------------------
// atsu_dp: datapath of the authority time sync unit
// Holds sync state, config registers, a bit-serial divider for the mean delay,
// a divide-by-three multiplier and result regs.
// ----------------------------------------------------------------------------
module atsu_dp import atsu_pkg::*; #(
  parameter int unsigned TICK_SHIFT = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  atsu_cmd_t            cmd_i,
  output atsu_status_t         status_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic [1:0]           mode_i,
  input  logic [31:0]          now_seconds_i,
  input  logic [31:0]          send_time_i,
  input  logic [31:0]          recv_time_i,
  input  logic [15:0]          sender_level_i,
  input  logic [31:0]          delay_sample_i,
  input  logic                 about_self_i,
  output logic                 accepted_o,
  output logic [31:0]          clock_offset_o,
  output logic [15:0]          level_now_o,
  output logic [31:0]          corrected_at_o,
  output logic [31:0]          drift_bound_o
);

  localparam logic [31:0] MARGIN = 32'((64'd1 << TICK_SHIFT) >> 1);

  // configuration
  logic [15:0] timeout_q, start_level_q;

  // captured request
  mode_e       mode_q;
  logic [31:0] now_q, send_q, recv_q, sample_q;
  logic [15:0] sender_q;
  logic        self_q;

  // sync state
  logic [31:0] offset_q, offset_d;
  logic [15:0] level_q, level_d;
  logic [31:0] last_fix_q, last_fix_d;
  logic [15:0] count_q, count_d;
  logic [31:0] sum_q, sum_d;
  logic [15:0] countdown_q, countdown_d;
  logic        running_q, running_d;
  logic        acc_q, acc_d;

  // serial divider and drift span / 3
  logic [31:0] quo_q;
  logic [15:0] rem_q, divisor_q;
  logic [4:0]  step_q;
  logic [16:0] rem_shift, rem_trial;
  logic [31:0] span;
  logic [63:0] drift_prod;

  // result registers
  logic        acc_out_q;
  logic [31:0] offset_out_q, last_out_q, drift_out_q;
  logic [15:0] level_out_q;

  assign status_o.is_sync  = (mode_q == MODE_SYNC);
  assign status_o.div_last = (step_q == 5'd31);

  assign rem_shift  = {rem_q, quo_q[31]};
  assign rem_trial  = rem_shift - {1'b0, divisor_q};
  assign span       = (now_q - last_fix_q) << TICK_SHIFT;
  assign drift_prod = {32'd0, quo_q} * {32'd0, DRIFT_RECIP};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q   <= mode_e'(mode_i);
      now_q    <= now_seconds_i;
      send_q   <= send_time_i;
      recv_q   <= recv_time_i;
      sender_q <= sender_level_i;
      sample_q <= delay_sample_i;
      self_q   <= about_self_i;
    end
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      step_q <= '0;
      if (cmd_i.div_sel == DIV_SEL_DRIFT) begin
        quo_q <= span;
      end else begin
        quo_q     <= sum_q;
        divisor_q <= (count_q == '0) ? 16'd1 : count_q;
      end
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 5'd1;
      if (!rem_trial[16]) begin
        rem_q <= rem_trial[15:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_shift[15:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end else if (cmd_i.drift_mul) begin
      quo_q <= {1'b0, drift_prod[63:33]};
    end
    if (cmd_i.out_load) begin
      acc_out_q    <= acc_q;
      offset_out_q <= offset_q;
      level_out_q  <= level_q;
      last_out_q   <= last_fix_q;
      drift_out_q  <= (level_q == '0 && !self_q) ? '0 : MARGIN + quo_q;
    end
  end

  // state update for the captured request; for a sync packet quo_q holds the mean delay
  always_comb begin
    logic [31:0] recv_local;
    logic [16:0] sender_inc;
    logic [15:0] new_level;
    logic [15:0] cnt_pre;
    logic [31:0] sum_pre;
    offset_d    = offset_q;
    level_d     = level_q;
    last_fix_d  = last_fix_q;
    count_d     = count_q;
    sum_d       = sum_q;
    countdown_d = countdown_q;
    running_d   = running_q;
    acc_d       = 1'b0;
    recv_local  = recv_q - quo_q;
    sender_inc  = {1'b0, sender_q} + 17'd1;
    new_level   = sender_inc[16] ? LEVEL_MAX : sender_inc[15:0];
    cnt_pre     = (count_q > DELAY_COUNT_LIMIT) ? (count_q >> 2) : count_q;
    sum_pre     = (count_q > DELAY_COUNT_LIMIT) ? (sum_q >> 2) : sum_q;
    case (mode_q)
      MODE_INIT: begin
        offset_d    = '0;
        last_fix_d  = '0;
        count_d     = DELAY_COUNT_RESET;
        sum_d       = DELAY_SUM_RESET;
        level_d     = start_level_q;
        countdown_d = timeout_q;
        running_d   = 1'b1;
      end
      MODE_DELAY: begin
        sum_d   = sum_pre + sample_q;
        count_d = cnt_pre + 16'd1;
      end
      MODE_SYNC: begin
        if (last_fix_q == '0 ||
            (sender_inc <= {1'b0, level_q} && sender_q < SENDER_LEVEL_LIM)) begin
          offset_d   = offset_q + send_q - recv_local;
          last_fix_d = now_q;
          acc_d      = 1'b1;
          if (new_level != level_q) begin
            level_d     = new_level;
            countdown_d = timeout_q;
            running_d   = 1'b1;
          end
        end else if (level_q == '0) begin
          last_fix_d = now_q;
          acc_d      = 1'b1;
        end
      end
      MODE_TICK: begin
        if (running_q) begin
          if (countdown_q <= 16'd1) begin
            if (level_q != '0) begin
              if (level_q != LEVEL_MAX) level_d = level_q + 16'd1;
              countdown_d = timeout_q;
            end else begin
              countdown_d = '0;
              running_d   = 1'b0;
            end
          end else begin
            countdown_d = countdown_q - 16'd1;
          end
        end
      end
      default: acc_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= TIMEOUT_RESET;
      start_level_q <= LEVEL_RESET;
      offset_q      <= '0;
      level_q       <= LEVEL_RESET;
      last_fix_q    <= '0;
      count_q       <= DELAY_COUNT_RESET;
      sum_q         <= DELAY_SUM_RESET;
      countdown_q   <= TIMEOUT_RESET;
      running_q     <= 1'b1;
      acc_q         <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_TIMEOUT)     timeout_q     <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CFG_START_LEVEL) start_level_q <= cfg_data_i;
      if (cmd_i.apply) begin
        offset_q    <= offset_d;
        level_q     <= level_d;
        last_fix_q  <= last_fix_d;
        count_q     <= count_d;
        sum_q       <= sum_d;
        countdown_q <= countdown_d;
        running_q   <= running_d;
        acc_q       <= acc_d;
      end
    end
  end

  assign accepted_o     = acc_out_q;
  assign clock_offset_o = offset_out_q;
  assign level_now_o    = level_out_q;
  assign corrected_at_o = last_out_q;
  assign drift_bound_o  = drift_out_q;

`ifndef ASSERT_OFF
  a_stopped_is_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> level_q == '0)
    else $error("aging stopped at a nonzero level");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= DELAY_COUNT_RESET && count_q <= DELAY_COUNT_MAX)
    else $error("delay count out of range");
  a_accept_only_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && mode_q != MODE_SYNC |=> !acc_q)
    else $error("accepted flag set outside a sync packet");
`endif

endmodule

### design/authority_time_sync_unit.sv
// ----------------------------------------------------------------------------
// authority_time_sync_unit: authority-level time synchronization
// Tracks clock offset, authority level, last correction and delay statistics.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  in        in         in_valid_i/in_stall_o   mode, times, sender level, sample
//  out       out        out_valid_o/out_stall_i accepted, offset, level, drift
//  cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  Sequence: one request at a time. For a sync packet the accepting edge is
//  followed by dispatch, 32 steps of the bit-serial mean-delay divider,
//  update, span load, span / 3 by reciprocal multiply and result load, with
//  which out_valid_o rises. Any other mode skips the divider. The next
//  request is taken once the sequencer has returned to idle.
//  Reset: asynchronous, active low; state and config take their reset values.
//  Stalls: the next request is taken while a result waits; the finished
//  result then holds in the sequencer until the output register frees.
//  Config writes are always ready and are meant for idle periods only.
//
module authority_time_sync_unit import atsu_pkg::*; #(
  parameter int unsigned TICK_SHIFT = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           mode_i,
  input  logic [31:0]          now_seconds_i,
  input  logic [31:0]          send_time_i,
  input  logic [31:0]          recv_time_i,
  input  logic [15:0]          sender_level_i,
  input  logic [31:0]          delay_sample_i,
  input  logic                 about_self_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 accepted_o,
  output logic [31:0]          clock_offset_o,
  output logic [15:0]          level_now_o,
  output logic [31:0]          corrected_at_o,
  output logic [31:0]          drift_bound_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  atsu_cmd_t    cmd;
  atsu_status_t status;

  // register writes never back-pressure
  assign cfg_ready_o = 1'b1;

  atsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  atsu_dp #(
    .TICK_SHIFT (TICK_SHIFT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .now_seconds_i  (now_seconds_i),
    .send_time_i    (send_time_i),
    .recv_time_i    (recv_time_i),
    .sender_level_i (sender_level_i),
    .delay_sample_i (delay_sample_i),
    .about_self_i   (about_self_i),
    .accepted_o     (accepted_o),
    .clock_offset_o (clock_offset_o),
    .level_now_o    (level_now_o),
    .corrected_at_o (corrected_at_o),
    .drift_bound_o  (drift_bound_o)
  );

endmodule
